[hdl/mbss_pkg.sv]
// ----------------------------------------------------------------------------
// mbss_pkg
// Shared types and constants for the masked byte signature scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mbss_pkg;

	// Default window depth, in bytes; the top level may be built from 1 to 32.
	localparam int unsigned PATTERN_MAX_DEF = 16;

	// Signature bytes held in the configuration registers.
	localparam int unsigned SIG_BYTES = 16;
	localparam int unsigned SIG_IDX_W = 4;

	// Wide enough for a clamped length up to the largest window (32).
	localparam int unsigned LEN_W = 6;

	localparam int unsigned POS_W = 32;
	localparam int unsigned ADDR_W = 64;
	localparam int unsigned CFG_IDX_W = 3;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EARLIEST_START = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 3'd5;

	typedef struct packed {
		logic [8*SIG_BYTES-1:0] pattern;        // byte k at bits 8k+7..8k
		logic [SIG_BYTES-1:0]   care_mask;
		logic [4:0]             pattern_length;
		logic [POS_W-1:0]       earliest_start;
		logic [ADDR_W-1:0]      base_address;
	} cfg_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

`default_nettype wire

[hdl/mbss_region_if.sv]
// ----------------------------------------------------------------------------
// mbss_region_if
// Byte stream channel into the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbss_region_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[hdl/mbss_report_if.sv]
// ----------------------------------------------------------------------------
// mbss_report_if
// Result channel out of the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbss_report_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [63:0] match_address;

	modport source (output valid, output found, output match_address, input ready);
	modport sink (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

[hdl/mbss_cfg_if.sv]
// ----------------------------------------------------------------------------
// mbss_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbss_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  wr_index;
	logic [63:0] wr_data;

	modport source (output valid, output wr_index, output wr_data, input ready);
	modport sink (input valid, input wr_index, input wr_data, output ready);
endinterface

`default_nettype wire

[hdl/masked_byte_signature_scan.sv]
// ----------------------------------------------------------------------------
// masked_byte_signature_scan
// Finds the first place in a streamed byte region where a masked signature of
// up to 16 bytes matches, and reports its address or not-found.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                       notes
//  -------  ---  ----------------------------  --------------------------------
//  region   in   data_byte[8], last_byte       one byte per request
//  report   out  found, match_address[64]      at most one per region
//  cfg      in   wr_index[3], wr_data[64]      always ready; write when idle
//
//  One byte is taken every cycle unless the input stalls; the result of a byte
//  sits in the output register in the cycle after the byte is taken.
//  The input stalls only while a result waits in the output register and the
//  sink is not taking it in the same cycle.
//  Reset clears the window, position and reported flag; registers take their
//  power-on values (care mask all ones, length one, everything else zero).
//  The window is a chain of PATTERN_MAX cells, one byte each, all shifting on
//  an accepted byte (cleared instead on a region's last byte) and comparing in parallel.
//
`default_nettype none

module masked_byte_signature_scan #(
	parameter int unsigned PATTERN_MAX = mbss_pkg::PATTERN_MAX_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mbss_region_if.sink  region,
	mbss_report_if.source report,
	mbss_cfg_if.sink   cfg
);
	import mbss_pkg::*;

	cfg_t cfg_q;

	mbss_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	// ---- handshake ---------------------------------------------------------
	logic out_valid_q;
	logic found_q;
	logic [ADDR_W-1:0] addr_q;
	logic accept;

	// Output register frees up in the same cycle it is taken.
	assign region.ready = !out_valid_q || report.ready;
	assign accept       = region.valid && region.ready;

	// ---- effective length: lengths above the window depth are clamped ----
	logic [LEN_W-1:0] len_ext;
	logic [LEN_W-1:0] len_eff;
	assign len_ext = LEN_W'(cfg_q.pattern_length);
	assign len_eff = (len_ext > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_ext;

	// ---- cell chain --------------------------------------------------------
	cell_ctl_t ctl;
	logic [7:0] win [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] cell_hit;

	assign ctl = '{shift: accept, clear: accept && region.last_byte};

	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
		logic [7:0] in_byte;
		if (j == PATTERN_MAX - 1) begin : g_head
			assign in_byte = region.data_byte;   // newest byte enters at the top
		end else begin : g_body
			assign in_byte = win[j+1];
		end

		mbss_cell #(
			.PATTERN_MAX (PATTERN_MAX),
			.POS         (j)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.in_byte (in_byte),
			.cfg     (cfg_q),
			.len_eff (len_eff),
			.byte_q  (win[j]),
			.hit     (cell_hit[j])
		);
	end

	// ---- position and match decision ---------------------------------------
	logic [POS_W-1:0] pos_q;
	logic             reported_q;
	logic             pos_sat;
	logic             len_zero;
	logic [POS_W:0]   pos_inc;
	logic             ok;
	logic [POS_W-1:0] start;
	logic             hit;
	logic             emit;

	assign pos_sat  = &pos_q;           // saturated: no further match can end
	assign len_zero = len_eff == '0;
	assign pos_inc  = {1'b0, pos_q} + (POS_W+1)'(1);
	// Enough bytes seen to hold the whole signature in this region.
	assign ok       = len_zero || (pos_inc >= (POS_W+1)'(len_eff));
	// Empty signature starts at the current byte, otherwise len-1 bytes back.
	assign start    = len_zero ? pos_q : POS_W'(pos_inc - (POS_W+1)'(len_eff));

	assign hit  = !reported_q && !pos_sat && ok && (start >= cfg_q.earliest_start)
		&& (&cell_hit);
	// A not-found report goes out only at region end with nothing reported.
	assign emit = hit || (region.last_byte && !reported_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (region.last_byte) begin
				pos_q      <= '0;
				reported_q <= 1'b0;
			end else begin
				if (!pos_sat) begin
					pos_q <= pos_inc[POS_W-1:0];
				end
				if (hit) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	// ---- output register ---------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			found_q <= hit;
			addr_q  <= hit ? (cfg_q.base_address + ADDR_W'(start)) : '0;
		end
	end

	assign report.valid         = out_valid_q;
	assign report.found         = found_q;
	assign report.match_address = addr_q;

	// ---- checks ------------------------------------------------------------
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && region.last_byte |=> (pos_q == '0) && !reported_q)
		else $error("region end did not clear position state");

	a_found_latches: assert property (@(posedge clk) disable iff (!arst_n)
		accept && hit && !region.last_byte |=> reported_q)
		else $error("match not recorded as reported");

	a_notfound_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit && !hit |-> region.last_byte)
		else $error("not-found emitted before region end");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> addr_q == '0)
		else $error("not-found carries an address");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !report.ready |=> out_valid_q && $stable(addr_q) && $stable(found_q))
		else $error("pending result lost or overwritten");

endmodule

`default_nettype wire

[hdl/mbss_cfg_regs.sv]
// ----------------------------------------------------------------------------
// mbss_cfg_regs
// Configuration register file; always ready, unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module mbss_cfg_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	mbss_cfg_if.sink         cfg,
	output mbss_pkg::cfg_t   cfg_q
);
	import mbss_pkg::*;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern        <= '0;
			cfg_q.care_mask      <= '1;
			cfg_q.pattern_length <= 5'd1;
			cfg_q.earliest_start <= '0;
			cfg_q.base_address   <= '0;
		end else if (cfg.valid) begin
			case (cfg.wr_index)
				CFG_PATTERN_LOW: begin
					cfg_q.pattern[63:0] <= cfg.wr_data;
				end
				CFG_PATTERN_HIGH: begin
					cfg_q.pattern[127:64] <= cfg.wr_data;
				end
				CFG_CARE_MASK: begin
					cfg_q.care_mask <= cfg.wr_data[SIG_BYTES-1:0];
				end
				CFG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= cfg.wr_data[4:0];
				end
				CFG_EARLIEST_START: begin
					cfg_q.earliest_start <= cfg.wr_data[POS_W-1:0];
				end
				CFG_BASE_ADDRESS: begin
					cfg_q.base_address <= cfg.wr_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/mbss_cell.sv]
// ----------------------------------------------------------------------------
// mbss_cell
// One window byte: shifts in its neighbour's byte and compares it with the
// signature byte that lines up with this slot for the current length.
// ----------------------------------------------------------------------------
`default_nettype none

module mbss_cell #(
	parameter int unsigned PATTERN_MAX = mbss_pkg::PATTERN_MAX_DEF,
	parameter int unsigned POS = 0
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire mbss_pkg::cell_ctl_t        ctl,
	input  wire logic [7:0]                 in_byte,
	input  wire mbss_pkg::cfg_t             cfg,
	input  wire logic [mbss_pkg::LEN_W-1:0] len_eff,
	output logic [7:0]                      byte_q,
	output logic                            hit
);
	import mbss_pkg::*;

	logic [LEN_W:0]       sum;
	logic [LEN_W:0]       sig_k;
	logic                 active;
	logic                 care;
	logic [7:0]           sig_byte;
	logic [SIG_IDX_W-1:0] k_idx;

	// Slot POS holds signature byte POS + len - PATTERN_MAX, if that is >= 0.
	assign sum    = (LEN_W+1)'(POS) + {1'b0, len_eff};
	assign active = sum >= (LEN_W+1)'(PATTERN_MAX);
	assign sig_k  = sum - (LEN_W+1)'(PATTERN_MAX);
	assign k_idx  = sig_k[SIG_IDX_W-1:0];

	assign sig_byte = cfg.pattern[{k_idx, 3'b000} +: 8];
	assign care     = active && (sig_k < (LEN_W+1)'(SIG_BYTES)) && cfg.care_mask[k_idx];
	assign hit      = !care || (in_byte == sig_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.clear) begin
			byte_q <= '0;
		end else if (ctl.shift) begin
			byte_q <= in_byte;
		end
	end

endmodule

`default_nettype wire
